// File: hdl/eatf_pkg.sv
// shared constants, types and state encoding for the edge adjacent triangle finder
`default_nettype none
package eatf_pkg;

	// table geometry
	localparam int MaxTriangles = 1024;
	localparam int SlotW        = $clog2(MaxTriangles);
	localparam int CountW       = 11;
	localparam int VertW        = 16;
	localparam int EntryW       = 3 * VertW;

	// query sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPORT
	} state_t;

	// input mode codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// outcome of testing one table entry against the edge
	typedef struct packed {
		logic             hit;
		logic [VertW-1:0] opp;
	} match_t;

endpackage
`default_nettype wire

// File: hdl/edge_adjacent_triangle_finder.sv
// top level: triangle table, scan sequencer and result registers
// Usage:
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. mode selects a load (write vertex_a/b/c into table entry slot) or a
//   query (find triangles holding the edge vertex_a, vertex_b).
//   A load returns nothing; busy stays low.
//   A query raises busy and scans entries 0 to triangle_count-1 (clamped to the
//   table depth) through one shared edge test unit, one entry per cycle, read
//   from a single table ram with registered read. It finishes early once a
//   second match is seen. The next item may start in the cycle after the result
//   strobe.
//   Result: done is high for exactly one cycle with the result fields valid in
//   that cycle; the receiver cannot stall and must take it then.
//   Config: cfg_valid/cfg_ready write triangle_count; cfg_ready is always high;
//   the user must see that writes are only made while busy is low (unenforced).
//   Reset: arst_n clears the sequencer and triangle_count; table contents are
//   undefined until loaded.
`default_nettype none
module edge_adjacent_triangle_finder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        mode,
	input  wire logic [eatf_pkg::SlotW-1:0]  slot,
	input  wire logic [eatf_pkg::VertW-1:0]  vertex_a,
	input  wire logic [eatf_pkg::VertW-1:0]  vertex_b,
	input  wire logic [eatf_pkg::VertW-1:0]  vertex_c,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [eatf_pkg::CountW-1:0] cfg_data,
	output logic                             done,
	output logic                             pair_found,
	output logic                             first_found,
	output logic [eatf_pkg::SlotW-1:0]       first_triangle,
	output logic [eatf_pkg::VertW-1:0]       first_opposite,
	output logic [eatf_pkg::SlotW-1:0]       second_triangle,
	output logic [eatf_pkg::VertW-1:0]       second_opposite
);
	import eatf_pkg::*;

	state_t              state_q, state_d;
	logic [CountW-1:0]   count_q;
	logic [CountW-1:0]   limit_q;
	logic [CountW-1:0]   issue_q;
	logic [VertW-1:0]    a_q, b_q;
	logic                pend_s1;
	logic [SlotW-1:0]    idx_s1;
	logic                f1_q, f2_q;
	logic [SlotW-1:0]    t1_q, t2_q;
	logic [VertW-1:0]    o1_q, o2_q;
	logic                accept, load_we, query_go;
	logic                ram_re, issue_done, hit;
	logic [EntryW-1:0]   rd_entry;
	match_t              m;

	assign accept     = start && !busy;
	assign load_we    = accept && (mode == MODE_LOAD);
	assign query_go   = accept && (mode == MODE_QUERY);
	assign issue_done = (issue_q == limit_q);
	assign hit        = pend_s1 && m.hit;
	assign cfg_ready  = 1'b1;

	// triangle table
	eatf_ram #(
		.WIDTH(EntryW),
		.DEPTH(MaxTriangles)
	) u_table (
		.clk  (clk),
		.we   (load_we),
		.waddr(slot),
		.wdata({vertex_c, vertex_b, vertex_a}),
		.re   (ram_re),
		.raddr(issue_q[SlotW-1:0]),
		.rdata(rd_entry)
	);

	// shared edge test
	eatf_match u_match (
		.entry (rd_entry),
		.edge_a(a_q),
		.edge_b(b_q),
		.result(m)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d = state_q;
		ram_re  = 1'b0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (mode == MODE_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_re = !issue_done;
				if (hit && f1_q) begin
					state_d = ST_REPORT;
				end else if (issue_done && !pend_s1) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// config register and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			issue_q <= '0;
			pend_s1 <= 1'b0;
			f1_q    <= 1'b0;
			f2_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			pend_s1 <= ram_re;
			if (query_go) begin
				issue_q <= '0;
				f1_q    <= 1'b0;
				f2_q    <= 1'b0;
			end else if (ram_re) begin
				issue_q <= issue_q + 1'b1;
			end
			if (state_q == ST_SCAN && hit) begin
				if (!f1_q) begin
					f1_q <= 1'b1;
				end else begin
					f2_q <= 1'b1;
				end
			end
		end
	end

	// query operands, read tag and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[SlotW-1:0];
		if (query_go) begin
			a_q  <= vertex_a;
			b_q  <= vertex_b;
			t1_q <= '0;
			t2_q <= '0;
			o1_q <= '0;
			o2_q <= '0;
			if (count_q > CountW'(MaxTriangles)) begin
				limit_q <= CountW'(MaxTriangles);
			end else begin
				limit_q <= count_q;
			end
		end else if (state_q == ST_SCAN && hit) begin
			if (!f1_q) begin
				t1_q <= idx_s1;
				o1_q <= m.opp;
			end else begin
				t2_q <= idx_s1;
				o2_q <= m.opp;
			end
		end
	end

	assign pair_found      = f2_q;
	assign first_found     = f1_q;
	assign first_triangle  = t1_q;
	assign first_opposite  = o1_q;
	assign second_triangle = t2_q;
	assign second_opposite = o2_q;

endmodule
`default_nettype wire

// File: hdl/eatf_ram.sv
// generic single write port ram with registered read
`default_nettype none
module eatf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/eatf_match.sv
// edge test unit shared by every step of the scan: one table entry per cycle
`default_nettype none
module eatf_match (
	input  wire logic [eatf_pkg::EntryW-1:0] entry,
	input  wire logic [eatf_pkg::VertW-1:0]  edge_a,
	input  wire logic [eatf_pkg::VertW-1:0]  edge_b,
	output eatf_pkg::match_t                 result
);
	import eatf_pkg::*;

	logic [VertW-1:0] v0, v1, v2;
	logic             on0, on1, on2;

	// split the entry and mark vertices that lie on the edge
	assign v0  = entry[VertW-1:0];
	assign v1  = entry[2*VertW-1:VertW];
	assign v2  = entry[3*VertW-1:2*VertW];
	assign on0 = (v0 == edge_a) || (v0 == edge_b);
	assign on1 = (v1 == edge_a) || (v1 == edge_b);
	assign on2 = (v2 == edge_a) || (v2 == edge_b);

	// try rotations in order, first one wins
	always_comb begin
		result.hit = 1'b0;
		result.opp = '0;
		if (!on0 && on1 && on2) begin
			result.hit = 1'b1;
			result.opp = v0;
		end else if (!on1 && on2 && on0) begin
			result.hit = 1'b1;
			result.opp = v1;
		end else if (!on2 && on0 && on1) begin
			result.hit = 1'b1;
			result.opp = v2;
		end
	end

endmodule
`default_nettype wire

// File: hdl/eatf_checker.sv
// port level checks for the edge adjacent triangle finder, bound to the top level
`default_nettype none
module eatf_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        mode,
	input wire logic                        done,
	input wire logic                        pair_found,
	input wire logic                        first_found,
	input wire logic [eatf_pkg::SlotW-1:0]  first_triangle,
	input wire logic [eatf_pkg::VertW-1:0]  first_opposite,
	input wire logic [eatf_pkg::SlotW-1:0]  second_triangle,
	input wire logic [eatf_pkg::VertW-1:0]  second_opposite
);
	import eatf_pkg::*;

	// a query beat always starts a busy period
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == MODE_QUERY) |=> busy)
		else $error("query accepted without going busy");

	// result strobe ends the busy period
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy)
		else $error("busy not released after result");

	// a pair implies a first match, in scan order
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && pair_found |-> first_found && (second_triangle > first_triangle))
		else $error("pair result out of order");

	// no match gives zeroed fields
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !first_found |-> (first_triangle == '0) && (first_opposite == '0)
			&& (second_triangle == '0) && (second_opposite == '0))
		else $error("fields not cleared on no match");

	// a single match leaves second fields zero
	a_single_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !pair_found |-> (second_triangle == '0) && (second_opposite == '0))
		else $error("second fields not cleared");

endmodule

bind edge_adjacent_triangle_finder eatf_checker u_eatf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.mode           (mode),
	.done           (done),
	.pair_found     (pair_found),
	.first_found    (first_found),
	.first_triangle (first_triangle),
	.first_opposite (first_opposite),
	.second_triangle(second_triangle),
	.second_opposite(second_opposite)
);
`default_nettype wire
